// File: hw/rtl/amt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amt_pkg: shared types and constants of the moving mean threshold
// Widths, tap counts, controller states, command and status structs, and the
// reciprocal table used for the division of a window sum by its length.
// ----------------------------------------------------------------------------
package amt_pkg;

  // window geometry
  localparam int PreTaps   = 8;
  localparam int PostTaps  = 7;
  localparam int HistDepth = PreTaps + PostTaps + 1;

  // field and internal widths
  localparam int SampleW = 16;
  localparam int SumW    = 20;
  localparam int PosW    = $clog2(HistDepth + 1);
  localparam int AgeW    = $clog2(PostTaps + 1);
  localparam int LenW    = $clog2(HistDepth);
  localparam int RecipW  = 24;
  localparam int ProdW   = SumW + RecipW;

  // controller states
  typedef enum logic [2:0] {
    StIdle,
    StCheck,
    StSetup,
    StMul,
    StFix,
    StShift
  } amt_state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic            shift_in;
    logic            shift_zero;
    logic            clear;
    logic            setup;
    logic            tail;
    logic [AgeW-1:0] age;
    logic            last;
    logic            mul;
    logic            load_out;
  } amt_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [PosW-1:0] jv;
    logic            out_free;
  } amt_status_t;

  // floor(2^24 / d) for window lengths, with d = 1 held one below 2^24
  function automatic logic [RecipW-1:0] recip(input logic [LenW-1:0] d);
    logic [RecipW-1:0] r;
    case (d)
      4'd1:    r = 24'd16777215;
      4'd2:    r = 24'd8388608;
      4'd3:    r = 24'd5592405;
      4'd4:    r = 24'd4194304;
      4'd5:    r = 24'd3355443;
      4'd6:    r = 24'd2796202;
      4'd7:    r = 24'd2396745;
      4'd8:    r = 24'd2097152;
      4'd9:    r = 24'd1864135;
      4'd10:   r = 24'd1677721;
      4'd11:   r = 24'd1525201;
      4'd12:   r = 24'd1398101;
      4'd13:   r = 24'd1290555;
      4'd14:   r = 24'd1198372;
      4'd15:   r = 24'd1118481;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/amt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amt_datapath: sample window, mean divider and output register
// Holds the sixteen-tap shift line with its running sum, forms the window sum
// and length of one result, divides by reciprocal multiply with one
// correction step, and registers the thresholded result.
// ----------------------------------------------------------------------------
module amt_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  amt_pkg::amt_cmd_t            cmd_i,
  output amt_pkg::amt_status_t         status_o,
  input  logic [amt_pkg::SampleW-1:0]  sample_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [amt_pkg::SampleW-1:0]  value_o,
  output logic                         last_res_o
);
  import amt_pkg::*;

  logic [SampleW-1:0] taps_q [HistDepth];
  logic [SumW-1:0]    total_q;
  logic [PosW-1:0]    pos_q;
  logic [PosW-1:0]    jv_q;
  logic [SampleW-1:0] first_q;

  logic [SumW-1:0]    sum_q;
  logic [LenW-1:0]    len_q;
  logic [SampleW-1:0] x_q;
  logic               res_last_q;
  logic [SumW-1:0]    qe_q;

  logic               out_valid_q;
  logic [SampleW-1:0] value_q;
  logic               last_res_q;

  logic [SampleW-1:0] shift_val;
  logic [PosW-1:0]    pos_inc;
  logic [SumW-1:0]    first_ext;
  logic [SumW-1:0]    tap0_ext;
  logic [SumW-1:0]    tap15_ext;
  logic               jv_le14;
  logic [PosW-1:0]    age_plus;
  logic [PosW-1:0]    len_tail;
  logic [SumW-1:0]    sum_d;
  logic [LenW-1:0]    len_d;
  logic [ProdW-1:0]   prod;
  logic [SumW-1:0]    qlen;
  logic [SumW-1:0]    rem;
  logic [SumW-1:0]    thr;
  logic [SumW-1:0]    x_ext;
  logic [SampleW-1:0] value_d;

  assign first_ext = {{(SumW-SampleW){1'b0}}, first_q};
  assign tap0_ext  = {{(SumW-SampleW){1'b0}}, taps_q[0]};
  assign tap15_ext = {{(SumW-SampleW){1'b0}}, taps_q[HistDepth-1]};
  assign shift_val = cmd_i.shift_in ? sample_i : '0;
  assign pos_inc   = (pos_q == PosW'(HistDepth)) ? pos_q : pos_q + 1'b1;

  // shift line, running sum and stream position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < HistDepth; k++) taps_q[k] <= '0;
      total_q <= '0;
      pos_q   <= '0;
      jv_q    <= '0;
      first_q <= '0;
    end else if (cmd_i.clear) begin
      for (int k = 0; k < HistDepth; k++) taps_q[k] <= '0;
      total_q <= '0;
      pos_q   <= '0;
    end else if (cmd_i.shift_in || cmd_i.shift_zero) begin
      taps_q[0] <= shift_val;
      for (int k = 1; k < HistDepth; k++) taps_q[k] <= taps_q[k-1];
      total_q <= total_q - tap15_ext + {{(SumW-SampleW){1'b0}}, shift_val};
      pos_q   <= pos_inc;
      if (cmd_i.shift_in) begin
        jv_q <= pos_q;
        if (pos_q == '0) first_q <= sample_i;
      end
    end
  end

  // window sum and length of the result at the selected age
  always_comb begin
    jv_le14  = (jv_q <= PosW'(HistDepth - 2));
    age_plus = {{(PosW-AgeW){1'b0}}, cmd_i.age} + PosW'(PreTaps);
    len_tail = (age_plus < jv_q) ? age_plus : jv_q;
    if (cmd_i.tail) begin
      sum_d = total_q - tap15_ext - ((pos_q < PosW'(HistDepth)) ? first_ext : '0);
      len_d = len_tail[LenW-1:0];
    end else if (jv_le14) begin
      sum_d = total_q - first_ext;
      len_d = jv_q[LenW-1:0];
    end else begin
      sum_d = total_q - tap0_ext;
      len_d = LenW'(HistDepth - 1);
    end
  end

  // setup stage
  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      sum_q      <= sum_d;
      len_q      <= len_d;
      x_q        <= taps_q[PostTaps];
      res_last_q <= cmd_i.last;
    end
  end

  // quotient estimate, at most one below the true mean
  assign prod = ProdW'(sum_q) * ProdW'(recip(len_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) qe_q <= prod[ProdW-1:RecipW];
  end

  // correction step and clamped difference
  always_comb begin
    qlen  = qe_q * SumW'(len_q);
    rem   = sum_q - qlen;
    x_ext = {{(SumW-SampleW){1'b0}}, x_q};
    if (len_q == '0) begin
      thr = '0;
    end else if (rem >= {{(SumW-LenW){1'b0}}, len_q}) begin
      thr = qe_q + 1'b1;
    end else begin
      thr = qe_q;
    end
    value_d = (x_ext > thr) ? SampleW'(x_ext - thr) : '0;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      value_q    <= value_d;
      last_res_q <= res_last_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign value_o           = value_q;
  assign last_res_o        = last_res_q;
  assign status_o.jv       = jv_q;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  // a held result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over a stalled transaction");

  // the final result of a stream leaves the window cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_out && res_last_q) |=> (pos_q == '0 && total_q == '0))
    else $error("window not cleared after end of stream");

  // a mean never exceeds the largest sample value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (thr[SumW-1:SampleW] == '0))
    else $error("threshold out of sample range");

endmodule

// File: hw/rtl/amt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amt_ctrl: sequencing of samples and end of stream flush
// Accepts one sample at a time, decides which results it causes and walks
// the datapath through setup, multiply and correction for each of them.
// ----------------------------------------------------------------------------
module amt_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  last_i,
  input  amt_pkg::amt_status_t  status_i,
  output amt_pkg::amt_cmd_t     cmd_o
);
  import amt_pkg::*;

  amt_state_e      state_q, state_d;
  logic [AgeW-1:0] age_q;
  logic            fin_q;
  logic            has_out;
  logic            age_mid;
  logic            age_zero;

  assign age_mid  = (age_q == AgeW'(PostTaps));
  assign age_zero = (age_q == '0);
  assign has_out  = (status_i.jv >= {{(PosW-AgeW){1'b0}}, age_q}) && (fin_q || age_mid);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StCheck;
      end
      StCheck: begin
        if (has_out) state_d = StSetup;
        else if (!fin_q || age_zero) state_d = StIdle;
        else state_d = StShift;
      end
      StSetup: state_d = StMul;
      StMul:   state_d = StFix;
      StFix: begin
        if (status_i.out_free) begin
          if (!fin_q || age_zero) state_d = StIdle;
          else state_d = StShift;
        end
      end
      StShift: state_d = StCheck;
      default: state_d = StIdle;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o            = '0;
    cmd_o.age        = age_q;
    cmd_o.tail       = fin_q && !age_mid;
    cmd_o.last       = fin_q && age_zero;
    in_stall_o       = 1'b1;
    case (state_q)
      StIdle: begin
        in_stall_o     = 1'b0;
        cmd_o.shift_in = in_valid_i;
      end
      StCheck: begin
        cmd_o.clear = fin_q && age_zero && !has_out;
      end
      StSetup: cmd_o.setup = 1'b1;
      StMul:   cmd_o.mul = 1'b1;
      StFix: begin
        cmd_o.load_out = status_i.out_free;
        cmd_o.clear    = status_i.out_free && fin_q && age_zero;
      end
      StShift: cmd_o.shift_zero = 1'b1;
      default: cmd_o = '0;
    endcase
  end

  // state, age of the next result and end of stream flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      age_q   <= '0;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StIdle && in_valid_i) begin
        age_q <= AgeW'(PostTaps);
        fin_q <= last_i;
      end else if (state_q == StShift) begin
        age_q <= age_q - 1'b1;
      end
    end
  end

  // one sample in flight: the cycle after a transaction the input is held off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second sample taken while busy");

  // the flush never shifts past the oldest result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StShift) |-> (fin_q && !age_zero))
    else $error("flush shift without a pending result");

  // the window is cleared only at the end of a stream
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clear |-> (fin_q && age_zero))
    else $error("window cleared in the middle of a stream");

endmodule

// File: hw/rtl/adaptive_moving_mean_threshold_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_moving_mean_threshold_top: local mean threshold of a sample stream
// Subtracts a clipped moving mean from each detection sample and clamps at 0.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid_i / in_stall_o with sample_i and last_i; one
//   sample is taken per transaction, last_i marks the end of a stream
//   output channel: out_valid_o / out_stall_i with value_o and last_res_o
//   results lag the input by seven samples; the sample marked last flushes
//   up to eight results, the final one carrying last_res_o
// sequencing
//   a sample that causes no result passes the check only, a sample with one
//   result passes check, window sum, reciprocal multiply, correction and load
//   into the output register; each flushed result adds one window shift plus
//   the same four steps
// reset and stall
//   reset clears the window, the running sum and the output valid; after
//   the last result of a stream the window returns to the same state
//   a stalled result is held in the output register while the next sample
//   is accepted and processed up to the point of loading its result
// ----------------------------------------------------------------------------
module adaptive_moving_mean_threshold_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [amt_pkg::SampleW-1:0]  sample_i,
  input  logic                         last_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [amt_pkg::SampleW-1:0]  value_o,
  output logic                         last_res_o
);
  import amt_pkg::*;

  amt_cmd_t    cmd;
  amt_status_t status;

  // sequencing
  amt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .last_i     (last_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // window, divider and output register
  amt_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .last_res_o  (last_res_o)
  );

endmodule

// File: sim/amt_threshold_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amt_threshold_checker: result predictor and scoreboard for the threshold
// Watches both channels of the moving mean threshold. Every accepted sample
// updates a private copy of the sample window and queues the results that
// it produces. Every accepted result is compared with the oldest queued one.
// ----------------------------------------------------------------------------
module amt_threshold_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [amt_pkg::SampleW-1:0] sample_i,
  input  logic                        last_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [amt_pkg::SampleW-1:0] value_i,
  input  logic                        last_res_i,
  output int                          err_cnt_o,
  output int                          pend_cnt_o
);
  import amt_pkg::*;

  // position marker used once the window has filled up
  localparam int unsigned SatPos   = 1024;
  localparam int          MaxShown = 10;

  typedef struct packed {
    logic [SampleW-1:0] value;
    logic               last;
  } thr_res_t;

  logic [SampleW-1:0] win_q [HistDepth];
  int unsigned        fill_cnt;
  thr_res_t           thr_q [$];

  initial begin
    err_cnt_o  = 0;
    pend_cnt_o = 0;
    fill_cnt   = 0;
    foreach (win_q[k]) win_q[k] = '0;
  end

  // window entry by age, zero beyond the window
  function automatic int unsigned tap(input int unsigned age);
    return (age < HistDepth) ? int'(win_q[age]) : 0;
  endfunction

  // sample idx minus the clipped local mean, clamped at zero
  function automatic logic [SampleW-1:0] mean_gap(input int unsigned newest,
                                                  input int unsigned idx,
                                                  input bit fin,
                                                  input int unsigned n);
    int unsigned lo, hi, k, sum, len, thr, x;
    sum = 0;
    if (fin && idx + PostTaps >= n) begin
      lo = (idx > PostTaps) ? idx - PostTaps : 0;
      if (lo < 1) lo = 1;
      hi = n;
    end else if (idx <= PostTaps) begin
      lo = 1;
      hi = idx + PreTaps;
      if (fin && hi > n) hi = n;
    end else begin
      lo = idx - PreTaps;
      hi = idx + PostTaps;
    end
    for (k = lo; k < hi; k++) begin
      if (k <= newest) sum += tap(newest - k);
    end
    len = (hi > lo) ? hi - lo : 0;
    thr = (len != 0) ? sum / len : 0;
    x   = (idx <= newest) ? tap(newest - idx) : 0;
    return (x > thr) ? SampleW'(x - thr) : '0;
  endfunction

  // shift one sample in and queue the results it releases
  task automatic predict(input logic [SampleW-1:0] s, input logic fin);
    int unsigned newest, n, first_idx, i;
    thr_res_t    res;
    newest = (fill_cnt < HistDepth) ? fill_cnt : SatPos;
    for (int k = HistDepth - 1; k > 0; k--) win_q[k] = win_q[k-1];
    win_q[0] = s;
    if (fill_cnt < HistDepth) fill_cnt++;
    if (!fin) begin
      if (newest >= PostTaps) begin
        res.value = mean_gap(newest, newest - PostTaps, 1'b0, 0);
        res.last  = 1'b0;
        thr_q.push_back(res);
      end
    end else begin
      n         = newest + 1;
      first_idx = (n > PostTaps + 1) ? n - PostTaps - 1 : 0;
      for (i = first_idx; i < n; i++) begin
        res.value = mean_gap(newest, i, 1'b1, n);
        res.last  = (i + 1 == n);
        thr_q.push_back(res);
      end
      // end of stream clears the window
      foreach (win_q[k]) win_q[k] = '0;
      fill_cnt = 0;
    end
  endtask

  // compare one result transaction with the oldest expectation
  task automatic check_result(input logic [SampleW-1:0] val, input logic lst);
    thr_res_t exp_res;
    if (thr_q.size() == 0) begin
      err_cnt_o++;
      if (err_cnt_o <= MaxShown)
        $display("%0t: unexpected result value=%0d last=%0b", $realtime, val, lst);
    end else begin
      exp_res = thr_q.pop_front();
      if (exp_res.value !== val || exp_res.last !== lst) begin
        err_cnt_o++;
        if (err_cnt_o <= MaxShown)
          $display("%0t: mismatch expected value=%0d last=%0b, got value=%0d last=%0b",
                   $realtime, exp_res.value, exp_res.last, val, lst);
      end
    end
  endtask

  // sample both channels at the clock edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) predict(sample_i, last_i);
      if (out_valid_i && !out_stall_i) check_result(value_i, last_res_i);
      pend_cnt_o = thr_q.size();
    end
  end

endmodule

// File: sim/adaptive_moving_mean_threshold_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_moving_mean_threshold_top_test: stream test of the mean threshold
// Sends directed streams (single samples, short streams, extreme values) and
// then random streams of random length through four idle and stall phases.
// The checker predicts every result; the verdict comes from its error and pending counts.
// ----------------------------------------------------------------------------
module adaptive_moving_mean_threshold_top_test;
  import amt_pkg::*;

  localparam int WatchLimit  = 2000;
  localparam int DrainLimit  = 5000;
  localparam int PhaseItems  = 22;
  localparam int NumPhases   = 4;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [SampleW-1:0] sample_i    = '0;
  logic               last_i      = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [SampleW-1:0] value_o;
  logic               last_res_o;

  int err_cnt;
  int pend_cnt;
  int idle_pct  = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  adaptive_moving_mean_threshold_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .last_res_o  (last_res_o)
  );

  amt_threshold_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .sample_i    (sample_i),
    .last_i      (last_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_i     (value_o),
    .last_res_i  (last_res_o),
    .err_cnt_o   (err_cnt),
    .pend_cnt_o  (pend_cnt)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // random output stall
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one sample transaction with random idle cycles ahead of it
  task automatic send_sample(input logic [SampleW-1:0] s, input logic fin);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    last_i     <= fin;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // sample values biased toward extremes and spikes
  function automatic logic [SampleW-1:0] rand_sample();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return SampleW'($urandom_range(255));
      3:       return SampleW'($urandom_range(65535, 49152));
      default: return SampleW'($urandom);
    endcase
  endfunction

  // random stream, mostly full length, sometimes short, cut to the phase budget
  task automatic send_stream(input int max_len, output int len);
    len = ($urandom_range(99) < 20) ? $urandom_range(15, 1) : $urandom_range(24, 16);
    if (len > max_len) len = max_len;
    for (int k = 0; k < len; k++) send_sample(rand_sample(), k == len - 1);
  endtask

  initial begin
    int len, phase_cnt, drain;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single sample streams at both extremes
    send_sample('1, 1'b1);
    send_sample('0, 1'b1);
    // short stream
    send_sample('0, 1'b0);
    send_sample('1, 1'b0);
    send_sample('0, 1'b0);
    send_sample('1, 1'b1);
    // stream just past the full window, every third sample at full scale, the rest zero
    for (int k = 0; k < 17; k++) send_sample((k % 3 == 0) ? '1 : '0, k == 16);

    // random streams over the idle and stall phases
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 67; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 67; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      phase_cnt = 0;
      while (phase_cnt < PhaseItems) begin
        send_stream(PhaseItems - phase_cnt, len);
        phase_cnt += len;
      end
    end
    in_valid_i <= 1'b0;

    // drain outstanding results
    drain = 0;
    while (pend_cnt != 0 && drain < DrainLimit) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (50) @(posedge clk_i);

    if (err_cnt == 0 && pend_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/amt_pkg.sv
hw/rtl/amt_datapath.sv
hw/rtl/amt_ctrl.sv
hw/rtl/adaptive_moving_mean_threshold_top.sv
sim/amt_threshold_checker.sv
sim/adaptive_moving_mean_threshold_top_test.sv
